// ===== sv/fsc_pkg.sv =====
// fsc_pkg: shared types and constants for the flow sequence checker.
// Status codes, field widths and the lookup result struct.
// No dependencies.
package fsc_pkg;

    localparam int ADDR_W          = 48;
    localparam int RAW_W           = 16;
    localparam int SLOT_IDX_W      = 6;
    localparam int SEQ_W           = 8;
    localparam int DEF_SLOTS       = 2;
    localparam int DEF_SEQ_MODULUS = 10;

    typedef enum logic [1:0] {
        ST_IN_ORDER     = 2'd0,
        ST_OUT_OF_ORDER = 2'd1,
        ST_NO_SLOT      = 2'd2
    } fsc_status_t;

    typedef struct packed {
        fsc_status_t           status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [SEQ_W-1:0]      expected_sequence;
    } fsc_result_t;

endpackage

// ===== sv/fsc_seq_mod.sv =====
// fsc_seq_mod: reduces a 16-bit sequence number modulo SEQ_MODULUS.
// Two constant byte tables and one conditional subtract; uses fsc_pkg.
module fsc_seq_mod
    import fsc_pkg::*;
#(
    parameter int SEQ_MODULUS = DEF_SEQ_MODULUS
) (
    input  logic [RAW_W-1:0] raw,
    output logic [SEQ_W-1:0] reduced
);

    // hi_rom[b] = (b * 256) mod M, lo_rom[b] = b mod M
    logic [SEQ_W-1:0] hi_rom [256];
    logic [SEQ_W-1:0] lo_rom [256];

    for (genvar g = 0; g < 256; g++) begin : g_rom
        localparam int HiVal = (g * 256) % SEQ_MODULUS;
        localparam int LoVal = g % SEQ_MODULUS;
        assign hi_rom[g] = SEQ_W'(HiVal);
        assign lo_rom[g] = SEQ_W'(LoVal);
    end

    logic [SEQ_W:0] part_sum;

    always_comb begin
        part_sum = {1'b0, hi_rom[raw[15:8]]} + {1'b0, lo_rom[raw[7:0]]};
        if (part_sum >= (SEQ_W+1)'(SEQ_MODULUS)) begin
            reduced = SEQ_W'(part_sum - (SEQ_W+1)'(SEQ_MODULUS));
        end else begin
            reduced = part_sum[SEQ_W-1:0];
        end
    end

endmodule

// ===== sv/fsc_flow_table.sv =====
// fsc_flow_table: flow table with parallel address match, slot claim and
// expected-number update. Uses fsc_pkg.
module fsc_flow_table
    import fsc_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int SEQ_MODULUS = DEF_SEQ_MODULUS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic [ADDR_W-1:0] addr,
    input  logic [SEQ_W-1:0]  rx,
    output fsc_result_t       res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EXP_W = $clog2(SEQ_MODULUS);

    logic [SLOTS-1:0]  valid_reg;
    logic [ADDR_W-1:0] addr_reg [SLOTS];
    logic [EXP_W-1:0]  exp_reg  [SLOTS];

    logic [SLOTS-1:0] match;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] slot;
    logic             any_match;
    logic             any_free;
    logic             claim;
    logic             full;
    logic             in_order;
    logic [EXP_W-1:0] exp_cur;
    logic [EXP_W:0]   exp_inc;
    logic [EXP_W-1:0] exp_next;

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (addr_reg[i] == addr);
            if (match[i]) begin
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
        any_match = |match;
        any_free  = ~&valid_reg;
        claim     = !any_match && any_free;
        full      = !any_match && !any_free;
        slot      = any_match ? match_idx : free_idx;
        // a freshly claimed slot starts at zero
        exp_cur   = claim ? '0 : exp_reg[slot];
        in_order  = (rx == SEQ_W'(exp_cur));
        exp_inc   = {1'b0, exp_cur} + (EXP_W+1)'(1);
        exp_next  = (exp_inc == (EXP_W+1)'(SEQ_MODULUS)) ? '0 : exp_inc[EXP_W-1:0];

        if (full) begin
            res.status            = ST_NO_SLOT;
            res.slot_index        = '0;
            res.expected_sequence = '0;
        end else begin
            res.status            = in_order ? ST_IN_ORDER : ST_OUT_OF_ORDER;
            res.slot_index        = SLOT_IDX_W'(slot);
            res.expected_sequence = SEQ_W'(exp_cur);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (fire && claim) begin
            valid_reg[slot] <= 1'b1;
        end
    end

    // entries are written on claim, so they need no reset
    always_ff @(posedge aclk) begin
        if (fire && claim) begin
            addr_reg[slot] <= addr;
            exp_reg[slot]  <= in_order ? exp_next : '0;
        end else if (fire && !full && in_order) begin
            exp_reg[slot]  <= exp_next;
        end
    end

    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match))
        else $error("more than one flow entry matches");

    a_claim_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && claim |=> valid_reg[$past(slot)])
        else $error("claimed slot not marked valid");

    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((valid_reg & $past(valid_reg)) == $past(valid_reg)))
        else $error("slot valid flag cleared outside reset");

endmodule

// ===== sv/flow_sequence_checker.sv =====
// flow_sequence_checker: per-flow sequence number checker, stream in/out.
// Throughput: one item per cycle while m_tready does not stall the result stage;
// table lookup and update are one registered pass, from input stage to result stage.
// Reset: aresetn low clears all slot valid flags and both pipeline valids;
// no clearing pass, items are accepted in the first cycle after reset.
// Uses fsc_pkg, fsc_seq_mod and fsc_flow_table.
module flow_sequence_checker
    import fsc_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int SEQ_MODULUS = DEF_SEQ_MODULUS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: source_address [47:0], raw_sequence [63:48]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // m_tdata: slot_index [5:0], received_sequence [13:6],
    //          expected_sequence [21:14], zero pad [23:22]
    // m_tuser: status [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser
);

    // input stage
    logic              in_valid_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [RAW_W-1:0]  in_raw_reg;

    // result stage
    logic              out_valid_reg;
    fsc_result_t       out_res_reg;
    logic [SEQ_W-1:0]  out_rx_reg;

    logic              fire;
    logic              s_accept;
    logic [SEQ_W-1:0]  rx;
    fsc_result_t       res;

    // the item in the input stage is processed when the result stage
    // is empty or being drained this cycle
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    fsc_seq_mod #(
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_seq_mod (
        .raw     (in_raw_reg),
        .reduced (rx)
    );

    // table state changes only on fire, so the next item sees the update
    fsc_flow_table #(
        .SLOTS       (SLOTS),
        .SEQ_MODULUS (SEQ_MODULUS)
    ) u_flow_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .addr    (in_addr_reg),
        .rx      (rx),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_addr_reg <= s_tdata[47:0];
            in_raw_reg  <= s_tdata[63:48];
        end
        if (fire) begin
            out_res_reg <= res;
            out_rx_reg  <= rx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.expected_sequence, out_rx_reg,
                       out_res_reg.slot_index};
    assign m_tuser  = out_res_reg.status;

    a_rx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, out_rx_reg} < (SEQ_W+1)'(SEQ_MODULUS)))
        else $error("received sequence not reduced");

    a_no_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_res_reg.status == ST_NO_SLOT)
        |-> (out_res_reg.slot_index == '0) && (out_res_reg.expected_sequence == '0))
        else $error("no-slot result carries slot data");

    a_in_order_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_res_reg.status == ST_IN_ORDER)
        |-> (out_rx_reg == out_res_reg.expected_sequence))
        else $error("in-order status with mismatching numbers");

endmodule
